@@ hdl/lbpd_pkg.sv @@
// Package for the lamp and buzzer pattern driver: pattern and mode codes,
// channel state and configuration types, field widths.
// No dependencies.
package lbpd_pkg;

    localparam int NumChan   = 4;
    localparam int PatWidth  = 3;
    localparam int TickWidth = 8;
    localparam int ModeWidth = 3;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 8;

    typedef logic [PatWidth-1:0]  pattern_t;
    typedef logic [TickWidth-1:0] ticks_t;
    typedef logic [ModeWidth-1:0] mode_t;

    localparam pattern_t PAT_OFF    = 3'd0;
    localparam pattern_t PAT_ON     = 3'd1;
    localparam pattern_t PAT_SHORT  = 3'd2;
    localparam pattern_t PAT_LONG   = 3'd3;
    localparam pattern_t PAT_SQUARE = 3'd4;

    localparam mode_t MODE_TICK   = 3'd0;
    localparam mode_t MODE_BUZZER = 3'd1;
    localparam mode_t MODE_RED    = 3'd2;
    localparam mode_t MODE_GREEN  = 3'd3;
    localparam mode_t MODE_WHITE  = 3'd4;

    localparam logic [CfgIdxW-1:0] CFG_SHORT_TICKS  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_LONG_TICKS   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_SQUARE_TICKS = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_SOUND_ENABLE = 2'd3;

    localparam ticks_t SHORT_TICKS_RESET  = 8'd5;
    localparam ticks_t LONG_TICKS_RESET   = 8'd25;
    localparam ticks_t SQUARE_TICKS_RESET = 8'd10;

    typedef struct packed {
        ticks_t short_ticks;
        ticks_t long_ticks;
        ticks_t square_ticks;
        logic   sound_enable;
    } cfg_t;

    typedef struct packed {
        pattern_t pattern;
        ticks_t   timer;
        logic     status;
    } chan_state_t;

    typedef struct packed {
        logic     tick;
        logic     set;
        pattern_t pattern;
    } chan_cmd_t;

endpackage

@@ hdl/lbpd_channel.sv @@
// Next-state logic of one output channel (buzzer or lamp) for a tick or a
// pattern write. Depends on lbpd_pkg.
module lbpd_channel (
    input  lbpd_pkg::cfg_t        cfg,
    input  lbpd_pkg::chan_state_t cur,
    input  lbpd_pkg::chan_cmd_t   cmd,
    input  logic                  is_buzzer,
    output lbpd_pkg::chan_state_t nxt
);
    import lbpd_pkg::*;

    ticks_t timer_dec;
    ticks_t on_len;
    ticks_t off_len;

    assign timer_dec = cur.timer - 8'd1;

    always_comb
    begin
        if (cur.pattern == PAT_LONG)
        begin
            on_len  = cfg.long_ticks;
            off_len = cfg.short_ticks;
        end
        else
        begin
            on_len  = cfg.short_ticks;
            off_len = cfg.long_ticks;
        end
    end

    always_comb
    begin
        nxt = cur;
        if (cmd.set)
        begin
            nxt.pattern = cmd.pattern;
            case (cmd.pattern)
                PAT_SHORT:
                begin
                    nxt.timer  = cfg.short_ticks;
                    nxt.status = 1'b1;
                end
                PAT_LONG:
                begin
                    nxt.timer  = cfg.long_ticks;
                    nxt.status = 1'b1;
                end
                PAT_SQUARE:
                begin
                    nxt.timer  = cfg.square_ticks;
                    nxt.status = 1'b1;
                end
                PAT_ON:
                begin
                    if (is_buzzer)
                    begin
                        nxt.timer  = '0;
                        nxt.status = 1'b0;
                    end
                    else
                    begin
                        nxt.status = 1'b1;
                    end
                end
                default:
                begin
                    if (is_buzzer)
                    begin
                        nxt.timer = '0;
                    end
                    nxt.status = 1'b0;
                end
            endcase
        end
        else if (cmd.tick)
        begin
            case (cur.pattern) inside
                PAT_SHORT, PAT_LONG:
                begin
                    if (is_buzzer)
                    begin
                        // A beep runs once and then switches the channel off.
                        nxt.status = 1'b0;
                        if (cur.timer != '0)
                        begin
                            nxt.timer = timer_dec;
                            if (timer_dec != '0)
                            begin
                                nxt.status = 1'b1;
                            end
                            else
                            begin
                                nxt.pattern = PAT_OFF;
                            end
                        end
                    end
                    else if (cur.timer != '0)
                    begin
                        nxt.timer = timer_dec;
                        if (timer_dec == '0)
                        begin
                            nxt.status = ~cur.status;
                            nxt.timer  = cur.status ? off_len : on_len;
                        end
                    end
                end
                PAT_SQUARE:
                begin
                    if (cur.timer != '0)
                    begin
                        nxt.timer = timer_dec;
                        if (timer_dec == '0)
                        begin
                            nxt.status = ~cur.status;
                            nxt.timer  = cfg.square_ticks;
                        end
                    end
                end
                PAT_ON:
                begin
                    if (is_buzzer)
                    begin
                        nxt.status  = 1'b0;
                        nxt.pattern = PAT_OFF;
                    end
                    else
                    begin
                        nxt.status = 1'b1;
                    end
                end
                default:
                begin
                    nxt.status  = 1'b0;
                    nxt.pattern = PAT_OFF;
                end
            endcase
        end
    end

endmodule

@@ hdl/lamp_buzzer_pattern_driver.sv @@
// Top level of the lamp and buzzer pattern driver; depends on lbpd_pkg and lbpd_channel.
// A word accepted on the input is held in the input register, and its result is
// registered in the result register that drives m_tdata. Throughput: one word per
// cycle while m_tready is high, both sides may stream without gaps; the input
// register and the result register are each refilled in the cycle they drain.
// Reset (rst_n, asynchronous, active low) turns all channels off, clears timers
// and the buzzer pin, and loads the tick registers with 5, 25 and 10.
module lamp_buzzer_pattern_driver (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lbpd_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [lbpd_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [2:0] pattern, [7:3] zero
    input  logic [2:0]                     s_tuser,  // [2:0] mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] buzzer_out, [1] red_out, [2] green_out, [3] white_out, [7:4] zero
    output logic [7:0]                     m_tdata
);
    import lbpd_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    mode_t       in_mode_reg;
    pattern_t    in_pattern_reg;
    chan_state_t chan_reg  [NumChan];
    chan_state_t chan_next [NumChan];
    chan_cmd_t   chan_cmd  [NumChan];
    logic        buzzer_pin_reg;
    logic        buzzer_pin_next;
    logic        out_valid_reg;
    logic [3:0]  out_data_reg;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_ticks  <= SHORT_TICKS_RESET;
            cfg_reg.long_ticks   <= LONG_TICKS_RESET;
            cfg_reg.square_ticks <= SQUARE_TICKS_RESET;
            cfg_reg.sound_enable <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SHORT_TICKS:  cfg_reg.short_ticks  <= cfg_data;
                CFG_LONG_TICKS:   cfg_reg.long_ticks   <= cfg_data;
                CFG_SQUARE_TICKS: cfg_reg.square_ticks <= cfg_data;
                CFG_SOUND_ENABLE: cfg_reg.sound_enable <= cfg_data[0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_mode_reg    <= s_tuser;
            in_pattern_reg <= s_tdata[PatWidth-1:0];
        end
    end

    genvar g;
    generate
        for (g = 0; g < NumChan; g++)
        begin : g_chan
            assign chan_cmd[g].tick    = (in_mode_reg == MODE_TICK);
            assign chan_cmd[g].set     = (in_mode_reg == mode_t'(g + 1));
            assign chan_cmd[g].pattern = in_pattern_reg;

            lbpd_channel u_channel (
                .cfg       (cfg_reg),
                .cur       (chan_reg[g]),
                .cmd       (chan_cmd[g]),
                .is_buzzer ((g == 0) ? 1'b1 : 1'b0),
                .nxt       (chan_next[g])
            );

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    chan_reg[g] <= '{pattern: PAT_OFF, timer: '0, status: 1'b0};
                end
                else if (advance)
                begin
                    chan_reg[g] <= chan_next[g];
                end
            end
        end
    endgenerate

    always_comb
    begin
        buzzer_pin_next = buzzer_pin_reg;
        if (cfg_reg.sound_enable && (chan_cmd[0].tick || chan_cmd[0].set))
        begin
            buzzer_pin_next = chan_next[0].status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buzzer_pin_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                buzzer_pin_reg <= buzzer_pin_next;
                out_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {chan_next[3].status, chan_next[2].status,
                             chan_next[1].status, buzzer_pin_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg};

endmodule
